/* src/deq_pkg.sv */
// Shared types and codes for the double-ended queue core.
package deq_pkg;

    typedef enum logic [2:0] {
        ACT_NOTHING    = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_PUSH_BACK  = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_POP_BACK   = 3'd4,
        ACT_CLEAR      = 3'd5
    } action_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    typedef struct packed {
        logic exec;
        logic publish;
    } deq_cmd_t;

endpackage

/* src/deq_ctrl.sv */
// Controller: sequences one transaction from acceptance to the result register.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output deq_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign cmd.exec    = (state_reg == ST_IDLE) && s_valid;
    assign cmd.publish = (state_reg == ST_OUT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/deq_datapath.sv */
// Datapath: ring storage, indices, cached end values and result register.
module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  deq_cmd_t                  cmd,
    input  logic [2:0]                s_action,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic signed [VALUE_W-1:0] m_popped_value,
    output logic signed [VALUE_W-1:0] m_front_value,
    output logic signed [VALUE_W-1:0] m_back_value,
    output logic [COUNT_W-1:0]        m_entry_count,
    output logic [1:0]                m_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [AW-1:0]      fi_reg, fi_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               fix_front_reg, fix_front_next;
    logic               fix_back_reg, fix_back_next;
    logic [VALUE_W-1:0] front_val_reg, front_val_next;
    logic [VALUE_W-1:0] back_val_reg, back_val_next;
    logic [VALUE_W-1:0] popped_reg, popped_next;
    logic [1:0]         status_reg, status_next;
    logic [VALUE_W-1:0] rd_data_reg;

    logic [VALUE_W-1:0] m_popped_reg, m_front_reg, m_back_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic [1:0]         m_status_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      fi_dec;
    logic               full, empty;
    logic [VALUE_W-1:0] front_cur, back_cur;
    logic [CW+COUNT_W-1:0] cnt_ext;

    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [CW-1:0] k);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(k);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign full   = (cnt_reg >= FULL_CNT);
    assign empty  = (cnt_reg == '0);
    assign fi_dec = (fi_reg == '0) ? LAST_IDX : fi_reg - AW'(1);

    always_comb begin
        fi_next        = fi_reg;
        cnt_next       = cnt_reg;
        fix_front_next = fix_front_reg;
        fix_back_next  = fix_back_reg;
        front_val_next = front_val_reg;
        back_val_next  = back_val_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = ring_pos(fi_reg, cnt_reg);
        rd_addr        = ring_pos(fi_reg, CW'(1));
        if (cmd.exec) begin
            popped_next    = '0;
            status_next    = STATUS_OK;
            fix_front_next = 1'b0;
            fix_back_next  = 1'b0;
            case (s_action)
                ACT_PUSH_FRONT: begin
                    if (full) begin
                        status_next = STATUS_FULL;
                    end else begin
                        wr_en          = 1'b1;
                        wr_addr        = fi_dec;
                        fi_next        = fi_dec;
                        cnt_next       = cnt_reg + CW'(1);
                        front_val_next = s_value;
                        if (empty) begin
                            back_val_next = s_value;
                        end
                    end
                end
                ACT_PUSH_BACK: begin
                    if (full) begin
                        status_next = STATUS_FULL;
                    end else begin
                        wr_en         = 1'b1;
                        cnt_next      = cnt_reg + CW'(1);
                        back_val_next = s_value;
                        if (empty) begin
                            front_val_next = s_value;
                        end
                    end
                end
                ACT_POP_FRONT: begin
                    if (empty) begin
                        status_next = STATUS_EMPTY;
                    end else begin
                        popped_next    = front_val_reg;
                        fi_next        = ring_pos(fi_reg, CW'(1));
                        cnt_next       = cnt_reg - CW'(1);
                        fix_front_next = 1'b1;
                        rd_addr        = ring_pos(fi_reg, CW'(1));
                    end
                end
                ACT_POP_BACK: begin
                    if (empty) begin
                        status_next = STATUS_EMPTY;
                    end else begin
                        popped_next   = back_val_reg;
                        cnt_next      = cnt_reg - CW'(1);
                        fix_back_next = 1'b1;
                        rd_addr       = ring_pos(fi_reg, cnt_reg - CW'(2));
                    end
                end
                ACT_CLEAR: begin
                    fi_next  = '0;
                    cnt_next = '0;
                end
                default: begin
                end
            endcase
        end
        if (cmd.publish) begin
            fix_front_next = 1'b0;
            fix_back_next  = 1'b0;
            if (fix_front_reg) begin
                front_val_next = rd_data_reg;
            end
            if (fix_back_reg) begin
                back_val_next = rd_data_reg;
            end
        end
    end

    // Refresh after a pop comes from the ring; count zero reads as zero.
    assign front_cur = (cnt_reg == '0) ? '0 : (fix_front_reg ? rd_data_reg : front_val_reg);
    assign back_cur  = (cnt_reg == '0) ? '0 : (fix_back_reg ? rd_data_reg : back_val_reg);
    assign cnt_ext   = (CW+COUNT_W)'(cnt_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_value;
        end
        if (cmd.exec) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fi_reg        <= '0;
            cnt_reg       <= '0;
            fix_front_reg <= 1'b0;
            fix_back_reg  <= 1'b0;
        end else begin
            fi_reg        <= fi_next;
            cnt_reg       <= cnt_next;
            fix_front_reg <= fix_front_next;
            fix_back_reg  <= fix_back_next;
        end
    end

    always_ff @(posedge aclk) begin
        front_val_reg <= front_val_next;
        back_val_reg  <= back_val_next;
        popped_reg    <= popped_next;
        status_reg    <= status_next;
        if (cmd.publish) begin
            m_popped_reg <= popped_reg;
            m_front_reg  <= front_cur;
            m_back_reg   <= back_cur;
            m_count_reg  <= cnt_ext[COUNT_W-1:0];
            m_status_reg <= status_reg;
        end
    end

    assign m_popped_value = m_popped_reg;
    assign m_front_value  = m_front_reg;
    assign m_back_value   = m_back_reg;
    assign m_entry_count  = m_count_reg;
    assign m_status       = m_status_reg;

endmodule

/* src/double_ended_queue_core.sv */
// Double-ended queue core: top level joining controller and datapath.
// Result: after acceptance the controller enters ST_OUT and registers the result
// once the output register is free; no new transaction is accepted until then,
// as the ring's registered read refreshes the cached front or back entry after a pop.
// Reset: synchronous, active low; empties the queue, ring contents untouched.
module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_action,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_popped_value,
    output logic signed [VALUE_W-1:0] m_front_value,
    output logic signed [VALUE_W-1:0] m_back_value,
    output logic [COUNT_W-1:0]        m_entry_count,
    output logic [1:0]                m_status
);

    deq_cmd_t cmd;

    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_action       (s_action),
        .s_value        (s_value),
        .m_popped_value (m_popped_value),
        .m_front_value  (m_front_value),
        .m_back_value   (m_back_value),
        .m_entry_count  (m_entry_count),
        .m_status       (m_status)
    );

endmodule
